>>> rtl/rfc_pkg.sv
`default_nettype none

package rfc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = 5;
  localparam logic [CFG_AW-1:0] REG_RAILS = 1'b0;
  localparam logic [CFG_AW-1:0] REG_DIRECTION = 1'b1;

  localparam logic DIR_ENCRYPT = 1'b0;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       last_out;
    logic       truncated;
  } out_item_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ENC   = 6'b000010,
    ST_DCLR  = 6'b000100,
    ST_DCNT  = 6'b001000,
    ST_DSUM  = 6'b010000,
    ST_DEMIT = 6'b100000
  } state_e;

  // Second stage of a rail table read-modify-write
  typedef enum logic [1:0] {
    OP_INC  = 2'd0,
    OP_PSUM = 2'd1,
    OP_NEXT = 2'd2
  } rs_op_e;

endpackage

`default_nettype wire

>>> rtl/rail_fence_cipher.sv
`default_nettype none

// Rail fence permutation of a message of up to MAX_LEN bytes.
// The input channel takes one byte per request with a last marker; bytes are
// stored one per cycle, and a byte that finds the buffer full is dropped and
// flags every result of that message as truncated. Once the last byte is in,
// the input channel stalls while the permuted message is read out of the
// buffer memory, one result per byte, the final one marked last.
// Rails and direction come from the configuration port and are sampled with
// the last byte; a rail count below 2 acts as 2, above MAX_RAILS as MAX_RAILS.
// Encrypt: the buffer is read row by row, one buffer read per cycle while the
// output is not stalled, with a step past each exhausted row but the last.
// Decrypt: the rail start table (a small memory, read-modify-write through a
// second stage) is cleared, counted over the message, summed, and then
// each byte takes a rail pointer read, then a buffer read.
// A result waits in an output register while the receiver stalls; one more
// buffer read may be held behind it and later reads wait, so no result is lost.
// In decrypt the first result follows the clear, count and sum passes.
// Reset empties the buffer, sets rails to 2 and direction to encrypt.
module rail_fence_cipher #(
  parameter int unsigned MAX_LEN   = 64,
  parameter int unsigned MAX_RAILS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  rfc_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output rfc_pkg::out_item_t            out_data_o,
  input  wire                           cfg_we_i,
  input  wire [rfc_pkg::CFG_AW-1:0]     cfg_addr_i,
  input  wire [rfc_pkg::CFG_DW-1:0]     cfg_wdata_i
);
  import rfc_pkg::*;

  localparam int unsigned AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned RW  = (MAX_RAILS > 1) ? $clog2(MAX_RAILS) : 1;
  localparam int unsigned RCW = $clog2(MAX_RAILS + 1);
  localparam int unsigned PW  = $clog2(MAX_LEN + 2 * MAX_RAILS);

  // Configuration
  logic [CFG_DW-1:0] rails_q, rails_d;
  logic              dir_q, dir_d;

  // Message capture
  state_e            state_q, state_d;
  logic [LW-1:0]     len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [LW-1:0]     n_q, n_d;
  logic [RCW-1:0]    r_q, r_d;
  logic              trunc_q, trunc_d;

  // Sequencing
  logic [RCW-1:0]    zr_q, zr_d;
  logic              zd_q, zd_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic              phase_q, phase_d;
  logic [LW-1:0]     iss_q, iss_d;
  logic [RCW-1:0]    ctr_q, ctr_d;
  logic [LW-1:0]     acc_q, acc_d;

  // Rail table second stage
  logic              p1_valid_q, p1_valid_d;
  rs_op_e            p1_op_q, p1_op_d;
  logic [RW-1:0]     p1_addr_q, p1_addr_d;
  logic              p1_last_q, p1_last_d;

  // Buffer read and output register
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic              pend_trunc_q, pend_trunc_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  // Memories
  logic [7:0]        buf_mem [MAX_LEN];
  logic [7:0]        buf_rdata_q;
  logic              buf_we, buf_re;
  logic [AW-1:0]     buf_waddr, buf_raddr;
  logic [LW-1:0]     rs_mem [MAX_RAILS];
  logic [LW-1:0]     rs_rdata_q;
  logic              fwd_q;
  logic [LW-1:0]     fwd_val_q;
  logic              rs_we, rs_re;
  logic [RW-1:0]     rs_waddr, rs_raddr;
  logic [LW-1:0]     rs_wdata, rs_rd;

  logic              in_accept, room, out_free, can_issue, is_last;
  logic [RCW-1:0]    r_eff, rm1;
  logic [RCW-1:0]    zr_nxt;
  logic              zd_nxt;
  logic [PW-1:0]     cyc, d1, d2, delta;
  logic [LW-1:0]     n_m1, idx;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign room        = (len_q < LW'(MAX_LEN));
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign can_issue   = ~pend_q | out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign rs_rd       = fwd_q ? fwd_val_q : rs_rdata_q;
  assign rm1         = r_q - RCW'(1);
  assign n_m1        = n_q - LW'(1);
  assign is_last     = (iss_q == n_m1);
  assign idx         = (rs_rd >= LW'(MAX_LEN)) ? LW'(MAX_LEN - 1) : rs_rd;

  always_comb begin
    if (int'(rails_q) < 2) begin
      r_eff = RCW'(2);
    end else if (int'(rails_q) > int'(MAX_RAILS)) begin
      r_eff = RCW'(MAX_RAILS);
    end else begin
      r_eff = RCW'(rails_q);
    end
  end

  // Zigzag walk: bounce between row 0 and row R-1
  always_comb begin
    if (zd_q) begin
      if (zr_q == rm1) begin
        zr_nxt = zr_q - RCW'(1);
        zd_nxt = 1'b0;
      end else begin
        zr_nxt = zr_q + RCW'(1);
        zd_nxt = 1'b1;
      end
    end else begin
      if (zr_q == '0) begin
        zr_nxt = zr_q + RCW'(1);
        zd_nxt = 1'b1;
      end else begin
        zr_nxt = zr_q - RCW'(1);
        zd_nxt = 1'b0;
      end
    end
  end

  // Encrypt row stride: alternate 2(R-1-row) and 2*row, skipping zero steps
  always_comb begin
    cyc = (PW'(r_q) - PW'(1)) << 1;
    d2  = PW'(zr_q) << 1;
    d1  = cyc - d2;
    if (!phase_q) begin
      delta = (d1 != '0) ? d1 : d2;
    end else begin
      delta = (d2 != '0) ? d2 : d1;
    end
  end

  always_comb begin
    rails_d      = rails_q;
    dir_d        = dir_q;
    state_d      = state_q;
    len_d        = len_q;
    ovf_d        = ovf_q;
    n_d          = n_q;
    r_d          = r_q;
    trunc_d      = trunc_q;
    zr_d         = zr_q;
    zd_d         = zd_q;
    pos_d        = pos_q;
    phase_d      = phase_q;
    iss_d        = iss_q;
    ctr_d        = ctr_q;
    acc_d        = acc_q;
    p1_valid_d   = p1_valid_q;
    p1_op_d      = p1_op_q;
    p1_addr_d    = p1_addr_q;
    p1_last_d    = p1_last_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    pend_trunc_d = pend_trunc_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    buf_we       = 1'b0;
    buf_waddr    = len_q[AW-1:0];
    buf_re       = 1'b0;
    buf_raddr    = '0;
    rs_we        = 1'b0;
    rs_waddr     = p1_addr_q;
    rs_wdata     = '0;
    rs_re        = 1'b0;
    rs_raddr     = '0;

    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_RAILS:     rails_d = cfg_wdata_i;
        REG_DIRECTION: dir_d   = cfg_wdata_i[0];
        default: ;
      endcase
    end

    // Capture bytes
    if (in_accept) begin
      buf_we = room;
      if (in_data_i.last_in) begin
        n_d     = room ? len_q + LW'(1) : len_q;
        trunc_d = ovf_q | ~room;
        r_d     = r_eff;
        len_d   = '0;
        ovf_d   = 1'b0;
        zr_d    = '0;
        zd_d    = 1'b1;
        pos_d   = '0;
        phase_d = 1'b0;
        iss_d   = '0;
        ctr_d   = '0;
        state_d = (dir_q == DIR_ENCRYPT) ? ST_ENC : ST_DCLR;
      end else begin
        len_d = room ? len_q + LW'(1) : len_q;
        ovf_d = ovf_q | ~room;
      end
    end

    // Complete the rail table access held in the second stage
    if (p1_valid_q) begin
      case (p1_op_q)
        OP_INC: begin
          rs_we      = 1'b1;
          rs_wdata   = rs_rd + LW'(1);
          p1_valid_d = 1'b0;
        end
        OP_PSUM: begin
          rs_we      = 1'b1;
          rs_wdata   = acc_q;
          acc_d      = acc_q + rs_rd;
          p1_valid_d = 1'b0;
        end
        OP_NEXT: begin
          if (can_issue) begin
            rs_we        = 1'b1;
            rs_wdata     = rs_rd + LW'(1);
            buf_re       = 1'b1;
            buf_raddr    = idx[AW-1:0];
            pend_last_d  = p1_last_q;
            pend_trunc_d = trunc_q;
            p1_valid_d   = 1'b0;
          end
        end
        default: p1_valid_d = 1'b0;
      endcase
    end

    case (state_q)
      ST_IDLE: ;
      ST_ENC: begin
        if (PW'(n_q) > pos_q) begin
          if (can_issue) begin
            buf_re       = 1'b1;
            buf_raddr    = pos_q[AW-1:0];
            pend_last_d  = is_last;
            pend_trunc_d = trunc_q;
            pos_d        = pos_q + delta;
            phase_d      = ~phase_q;
            iss_d        = iss_q + LW'(1);
            if (is_last) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          // row exhausted: start the next one
          zr_d    = zr_q + RCW'(1);
          pos_d   = PW'(zr_q) + PW'(1);
          phase_d = 1'b0;
        end
      end
      ST_DCLR: begin
        rs_we    = 1'b1;
        rs_waddr = ctr_q[RW-1:0];
        rs_wdata = '0;
        ctr_d    = ctr_q + RCW'(1);
        if (ctr_q == rm1) begin
          state_d = ST_DCNT;
        end
      end
      ST_DCNT: begin
        rs_re      = 1'b1;
        rs_raddr   = zr_q[RW-1:0];
        p1_valid_d = 1'b1;
        p1_op_d    = OP_INC;
        p1_addr_d  = zr_q[RW-1:0];
        zr_d       = zr_nxt;
        zd_d       = zd_nxt;
        iss_d      = iss_q + LW'(1);
        if (is_last) begin
          ctr_d   = '0;
          acc_d   = '0;
          state_d = ST_DSUM;
        end
      end
      ST_DSUM: begin
        rs_re      = 1'b1;
        rs_raddr   = ctr_q[RW-1:0];
        p1_valid_d = 1'b1;
        p1_op_d    = OP_PSUM;
        p1_addr_d  = ctr_q[RW-1:0];
        ctr_d      = ctr_q + RCW'(1);
        if (ctr_q == rm1) begin
          zr_d    = '0;
          zd_d    = 1'b1;
          iss_d   = '0;
          state_d = ST_DEMIT;
        end
      end
      ST_DEMIT: begin
        if (!p1_valid_q) begin
          if (iss_q != n_q) begin
            rs_re      = 1'b1;
            rs_raddr   = zr_q[RW-1:0];
            p1_valid_d = 1'b1;
            p1_op_d    = OP_NEXT;
            p1_addr_d  = zr_q[RW-1:0];
            p1_last_d  = is_last;
            zr_d       = zr_nxt;
            zd_d       = zd_nxt;
            iss_d      = iss_q + LW'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Output register: take the buffer data when the slot frees up
    if (pend_q && out_free) begin
      out_valid_d        = 1'b1;
      out_d.out_symbol   = buf_rdata_q;
      out_d.last_out     = pend_last_q;
      out_d.truncated    = pend_trunc_q;
      pend_d             = 1'b0;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (buf_re) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rails_q     <= CFG_DW'(2);
      dir_q       <= DIR_ENCRYPT;
      state_q     <= ST_IDLE;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      p1_valid_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      rails_q     <= rails_d;
      dir_q       <= dir_d;
      state_q     <= state_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      p1_valid_q  <= p1_valid_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (rs_re) begin
        fwd_q <= rs_we && (rs_waddr == rs_raddr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    r_q          <= r_d;
    trunc_q      <= trunc_d;
    zr_q         <= zr_d;
    zd_q         <= zd_d;
    pos_q        <= pos_d;
    phase_q      <= phase_d;
    iss_q        <= iss_d;
    ctr_q        <= ctr_d;
    acc_q        <= acc_d;
    p1_op_q      <= p1_op_d;
    p1_addr_q    <= p1_addr_d;
    p1_last_q    <= p1_last_d;
    pend_last_q  <= pend_last_d;
    pend_trunc_q <= pend_trunc_d;
    out_q        <= out_d;
    if (rs_re) begin
      fwd_val_q <= rs_wdata;
    end
  end

  // Message buffer
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= in_data_i.symbol;
    end
    if (buf_re) begin
      buf_rdata_q <= buf_mem[buf_raddr];
    end
  end

  // Rail count / start table
  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rs_waddr] <= rs_wdata;
    end
    if (rs_re) begin
      rs_rdata_q <= rs_mem[rs_raddr];
    end
  end

endmodule

`default_nettype wire
